/* rtl/bsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int NUM_SLOTS_DEF = 128;
	localparam int WORD_BITS_DEF = 32;

	localparam int SLOT_W = 8;
	localparam int STATUS_W = 3;

	localparam logic [SLOT_W-1:0] SLOT_NONE = '1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTALLOC = 3'd3,
		ST_IGNORED  = 3'd4
	} status_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} find_res_t;

endpackage

/* rtl/bsa_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_find
// Free-slot search: lowest word with a free slot, highest free slot within it.
// ----------------------------------------------------------------------------
module bsa_find #(
	parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
	input  logic [NUM_SLOTS-1:0] used,
	output bsa_pkg::find_res_t   res
);

	localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;

	logic [NUM_WORDS-1:0]          word_hit;
	logic [bsa_pkg::SLOT_W-1:0]    word_slot [NUM_WORDS];

	for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
		logic [WORD_BITS-1:0] free_w;

		for (genvar j = 0; j < WORD_BITS; j++) begin : g_bit
			if (w * WORD_BITS + j < NUM_SLOTS) begin : g_live
				assign free_w[j] = ~used[w * WORD_BITS + j];
			end else begin : g_pad
				assign free_w[j] = 1'b0;
			end
		end

		// highest free slot of the word
		always_comb begin
			word_slot[w] = bsa_pkg::SLOT_NONE;
			for (int j = 0; j < WORD_BITS; j++) begin
				if (free_w[j]) begin
					word_slot[w] = bsa_pkg::SLOT_W'(w * WORD_BITS + j);
				end
			end
		end

		assign word_hit[w] = |free_w;
	end

	// lowest word with a free slot
	always_comb begin
		res.found = |word_hit;
		res.slot  = bsa_pkg::SLOT_NONE;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (word_hit[w]) begin
				res.slot = word_slot[w];
			end
		end
	end

endmodule

/* rtl/bitmap_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Slot allocator over a register bitmap with allocate and release requests.
// ----------------------------------------------------------------------------
// One request per cycle unless out_ready stalls the result, one result per
// request. A request is registered in stage s1, the bitmap lookup (a priority
// encode over all slots for allocate, a single bit test for release) runs on
// it, and the result register is loaded. The bitmap is updated on the same
// edge that loads the result register, so the next request already sees the
// change. Allocate takes the lowest word that has a free slot and, inside it,
// the highest-numbered free slot. The bitmap is cleared by reset. The result
// register lets a new request in while a result waits to be taken.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top #(
	parameter int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [bsa_pkg::SLOT_W-1:0]   slot_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bsa_pkg::STATUS_W-1:0] status,
	output logic [bsa_pkg::SLOT_W-1:0]   slot_number
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [bsa_pkg::SLOT_W-1:0] SLOT_LIMIT = bsa_pkg::SLOT_W'(NUM_SLOTS);

	logic                       valid_s1;
	logic                       req_type_s1;
	logic [bsa_pkg::SLOT_W-1:0] slot_index_s1;

	logic [NUM_SLOTS-1:0]       used_q;
	logic [NUM_SLOTS-1:0]       used_d;

	logic                       out_valid_q;
	bsa_pkg::status_t           status_q;
	logic [bsa_pkg::SLOT_W-1:0] slot_q;

	bsa_pkg::status_t           status_d;
	logic [bsa_pkg::SLOT_W-1:0] slot_d;
	bsa_pkg::find_res_t         find_res;
	logic                       advance;
	logic                       accept;
	logic                       rel_bit;
	logic [IDX_W-1:0]           rel_idx;
	logic [IDX_W-1:0]           alloc_idx;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1   <= req_type;
			slot_index_s1 <= slot_index;
		end
	end

	bsa_find #(
		.NUM_SLOTS(NUM_SLOTS),
		.WORD_BITS(WORD_BITS)
	) u_find (
		.used(used_q),
		.res (find_res)
	);

	assign rel_idx   = slot_index_s1[IDX_W-1:0];
	assign alloc_idx = find_res.slot[IDX_W-1:0];
	assign rel_bit   = used_q[rel_idx];

	always_comb begin
		used_d   = used_q;
		status_d = bsa_pkg::ST_FULL;
		slot_d   = bsa_pkg::SLOT_NONE;
		if (req_type_s1 == bsa_pkg::REQ_ALLOC) begin
			if (find_res.found) begin
				used_d[alloc_idx] = 1'b1;
				status_d          = bsa_pkg::ST_OK;
				slot_d            = find_res.slot;
			end
		end else if (slot_index_s1 == bsa_pkg::SLOT_NONE) begin
			status_d = bsa_pkg::ST_IGNORED;
		end else if (slot_index_s1 >= SLOT_LIMIT) begin
			status_d = bsa_pkg::ST_RANGE;
		end else if (!rel_bit) begin
			status_d = bsa_pkg::ST_NOTALLOC;
		end else begin
			used_d[rel_idx] = 1'b0;
			status_d        = bsa_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				used_q <= used_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			slot_q   <= slot_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_number = slot_q;

	// full is reported only when every slot is taken
	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 == bsa_pkg::REQ_ALLOC && !find_res.found |-> &used_q)
		else $error("allocate reported full with a free slot");

	// a granted allocate takes exactly one slot
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 == bsa_pkg::REQ_ALLOC && find_res.found
		|=> $countones(used_q) == $past($countones(used_q)) + 1)
		else $error("allocate did not take exactly one slot");

	// a successful release frees exactly one slot
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 == bsa_pkg::REQ_FREE && status_d == bsa_pkg::ST_OK
		|=> $countones(used_q) + 1 == $past($countones(used_q)))
		else $error("release did not free exactly one slot");

	// only a granted allocate carries a slot number
	a_slot_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != bsa_pkg::ST_OK |-> slot_q == bsa_pkg::SLOT_NONE)
		else $error("slot number given without a grant");

	// bitmap changes only when a request completes
	a_bitmap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(used_q))
		else $error("bitmap changed with no request");

endmodule

/* sim/tb_bitmap_slot_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_top
// Self-checking bench for the bitmap slot allocator.
// ----------------------------------------------------------------------------
// A local model of the slot bitmap predicts the status and slot number of
// every accepted request. A monitor pairs each reply with the oldest
// prediction. Directed requests hit the release error cases and the allocate
// order. Random phases then fill the bitmap to full, drain it, and mix both.
// Random gaps on the request side and random stalls on the reply side are
// used, except for one long stretch that runs with neither.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_top;

	localparam int NUM_SLOTS = bsa_pkg::NUM_SLOTS_DEF;
	localparam int WORD_BITS = bsa_pkg::WORD_BITS_DEF;
	localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;

	typedef struct {
		bsa_pkg::status_t           status;
		logic [bsa_pkg::SLOT_W-1:0] slot;
	} slot_reply_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         req_type = bsa_pkg::REQ_ALLOC;
	logic [bsa_pkg::SLOT_W-1:0]   slot_index = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [bsa_pkg::STATUS_W-1:0] status;
	logic [bsa_pkg::SLOT_W-1:0]   slot_number;

	bit [NUM_SLOTS-1:0] slot_in_use;
	slot_reply_t        replies_due[$];
	int                 err_count = 0;
	bit                 gaps_on = 1'b1;

	bitmap_slot_allocator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot_index (slot_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_number(slot_number)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("FAIL bitmap_slot_allocator_top");
		$finish;
	end

	// bitmap model: allocate scans words low to high, slots high to low within a word
	function automatic slot_reply_t predict_slot_reply(logic kind,
			logic [bsa_pkg::SLOT_W-1:0] idx);
		slot_reply_t r;
		int          s;
		r.status = bsa_pkg::ST_FULL;
		r.slot   = bsa_pkg::SLOT_NONE;
		if (kind == bsa_pkg::REQ_ALLOC) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				for (int b = WORD_BITS - 1; b >= 0; b--) begin
					s = w * WORD_BITS + b;
					if (s < NUM_SLOTS && !slot_in_use[s]) begin
						slot_in_use[s] = 1'b1;
						r.status = bsa_pkg::ST_OK;
						r.slot   = s[bsa_pkg::SLOT_W-1:0];
						return r;
					end
				end
			end
		end else if (idx == bsa_pkg::SLOT_NONE) begin
			r.status = bsa_pkg::ST_IGNORED;
		end else if (int'(idx) >= NUM_SLOTS) begin
			r.status = bsa_pkg::ST_RANGE;
		end else if (!slot_in_use[idx]) begin
			r.status = bsa_pkg::ST_NOTALLOC;
		end else begin
			slot_in_use[idx] = 1'b0;
			r.status = bsa_pkg::ST_OK;
		end
		return r;
	endfunction

	function automatic logic [bsa_pkg::SLOT_W-1:0] rand_index();
		return bsa_pkg::SLOT_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [bsa_pkg::SLOT_W-1:0] pick_used_slot();
		int start;
		int s;
		start = int'($urandom_range(0, NUM_SLOTS - 1));
		for (int i = 0; i < NUM_SLOTS; i++) begin
			s = (start + i) % NUM_SLOTS;
			if (slot_in_use[s])
				return s[bsa_pkg::SLOT_W-1:0];
		end
		return rand_index();
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(logic kind, logic [bsa_pkg::SLOT_W-1:0] idx);
		while (gaps_on && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		slot_index <= idx;
		do @(posedge clk); while (!in_ready);
		replies_due.push_back(predict_slot_reply(kind, idx));
		@(negedge clk);
	endtask

	task automatic send_random_release(int used_pct);
		if ($urandom_range(0, 99) < used_pct)
			send_request(bsa_pkg::REQ_FREE, pick_used_slot());
		else
			send_request(bsa_pkg::REQ_FREE, rand_index());
	endtask

	always @(negedge clk)
		out_ready <= !gaps_on || ($urandom_range(0, 99) >= 22);

	always @(posedge clk) begin : check_replies
		slot_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$error("reply with none outstanding: status %0d slot %0d", status, slot_number);
				err_count++;
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					err_count++;
				end
				if (slot_number !== want.slot) begin
					$error("slot_number: expected %0d, got %0d", want.slot, slot_number);
					err_count++;
				end
			end
		end
	end

	task automatic test_release_errors();
		send_request(bsa_pkg::REQ_FREE, bsa_pkg::SLOT_NONE);
		send_request(bsa_pkg::REQ_FREE, bsa_pkg::SLOT_W'(NUM_SLOTS));
		send_request(bsa_pkg::REQ_FREE, 8'd254);
		send_request(bsa_pkg::REQ_FREE, 8'd170);
		send_request(bsa_pkg::REQ_FREE, 8'd0);
		send_request(bsa_pkg::REQ_FREE, bsa_pkg::SLOT_W'(NUM_SLOTS - 1));
		send_request(bsa_pkg::REQ_FREE, 8'd85);
	endtask

	task automatic test_alloc_order();
		send_request(bsa_pkg::REQ_ALLOC, 8'd0);
		send_request(bsa_pkg::REQ_ALLOC, bsa_pkg::SLOT_NONE);
		send_request(bsa_pkg::REQ_ALLOC, 8'd77);
		send_request(bsa_pkg::REQ_ALLOC, 8'd200);
		send_request(bsa_pkg::REQ_FREE, 8'd30);
		send_request(bsa_pkg::REQ_ALLOC, 8'd0);
		send_request(bsa_pkg::REQ_FREE, 8'd31);
		send_request(bsa_pkg::REQ_FREE, 8'd31);
		send_request(bsa_pkg::REQ_FREE, 8'd28);
		send_request(bsa_pkg::REQ_ALLOC, 8'd0);
		send_request(bsa_pkg::REQ_ALLOC, 8'd0);
	endtask

	task automatic test_fill_to_full();
		for (int i = 0; i < 200; i++) begin
			if ($urandom_range(0, 99) < 85)
				send_request(bsa_pkg::REQ_ALLOC, rand_index());
			else
				send_random_release(70);
		end
		while (!(&slot_in_use))
			send_request(bsa_pkg::REQ_ALLOC, rand_index());
		repeat (6)
			send_request(bsa_pkg::REQ_ALLOC, rand_index());
	endtask

	task automatic test_drain();
		gaps_on = 1'b0;
		for (int i = 0; i < 200; i++) begin
			if ($urandom_range(0, 99) < 85)
				send_random_release(90);
			else
				send_request(bsa_pkg::REQ_ALLOC, rand_index());
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_mixed();
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_request(bsa_pkg::REQ_ALLOC, rand_index());
			else
				send_random_release(70);
		end
	endtask

	initial begin
		slot_in_use = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_release_errors();
		test_alloc_order();
		test_fill_to_full();
		test_drain();
		test_mixed();
		in_valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("PASS bitmap_slot_allocator_top");
		else
			$display("FAIL bitmap_slot_allocator_top");
		$finish;
	end

endmodule
